// ----- rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the best-fit block allocator: field widths,
// function and status codes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Default table geometry.
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Port field widths.
  localparam int FUNC_W   = 1;
  localparam int BIDX_W   = 4;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int CHOSEN_W = 4;
  localparam int LEFT_W   = 16;
  localparam int CFG_W    = 5;

  // Reset value of the blocks-in-use register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Function codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } bfa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take the accepted item and clear the search
    logic scan_issue;  // read the block at the scan index and step it
    logic finish;      // write the result register and update the table
  } bfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_is_alloc;  // the offered item is an allocation request
    logic count_zero;    // no block is in use
    logic scan_last;     // the scan index points at the last block in use
    logic out_free;      // the result register can take a new item
  } bfa_sts_t;

endpackage

// ----- rtl/bfa_in_if.sv -----
// ----------------------------------------------------------------------------
// bfa_in_if
// Input channel of the allocator: valid/ready handshake with the function,
// block index and size of one item.
// ----------------------------------------------------------------------------
interface bfa_in_if import bfa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BIDX_W-1:0] block_index;
  logic [SIZE_W-1:0] size;

  modport source (output valid, func, block_index, size, input ready);
  modport sink   (input valid, func, block_index, size, output ready);

endinterface

// ----- rtl/bfa_out_if.sv -----
// ----------------------------------------------------------------------------
// bfa_out_if
// Result channel of the allocator: valid/ready handshake with the status,
// chosen block and leftover of one item.
// ----------------------------------------------------------------------------
interface bfa_out_if import bfa_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHOSEN_W-1:0] chosen_block;
  logic [LEFT_W-1:0]   leftover;

  modport source (output valid, status, chosen_block, leftover, input ready);
  modport sink   (input valid, status, chosen_block, leftover, output ready);

endinterface

// ----- rtl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller of the allocator. Accepts one item at a time, steps the
// datapath through the best-fit scan and hands the result to the output
// register once that register is free.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  bfa_sts_t sts_i,
  output logic     in_ready_o,
  output bfa_cmd_t cmd_o
);

  bfa_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          if (sts_i.new_is_alloc && !sts_i.count_zero) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = accept_i;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
      end
      S_DRAIN: begin
        cmd_o = '0;
      end
      S_DONE: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- rtl/bfa_datapath.sv -----
// ----------------------------------------------------------------------------
// bfa_datapath
// Datapath of the allocator: block size memory, allocated flags, the
// blocks-in-use register, one compare stage for the scan and the result
// register.
// ----------------------------------------------------------------------------
module bfa_datapath import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  bfa_cmd_t            cmd_i,
  output bfa_sts_t            sts_o,
  input  logic [FUNC_W-1:0]   in_func_i,
  input  logic [BIDX_W-1:0]   in_block_index_i,
  input  logic [SIZE_W-1:0]   in_size_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [CHOSEN_W-1:0] out_chosen_block_o,
  output logic [LEFT_W-1:0]   out_leftover_o
);

  localparam int IdxW  = $clog2(MAX_BLOCKS);
  localparam int CntW  = $clog2(MAX_BLOCKS + 1);
  localparam int WideW = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int LeftW = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam logic [WideW-1:0] MaxCnt = WideW'(MAX_BLOCKS);

  // Storage.
  logic [SIZE_BITS-1:0]  mem_q [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] taken_q, taken_d;
  logic [CFG_W-1:0]      cfg_q;

  // Item and search registers.
  logic [FUNC_W-1:0]    func_q;
  logic [BIDX_W-1:0]    slot_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [IdxW-1:0]      idx_q;
  logic                 pipe_v_q;
  logic [IdxW-1:0]      cmp_idx_q;
  logic [SIZE_BITS-1:0] rd_size_q;
  logic                 rd_taken_q;
  logic                 found_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [SIZE_BITS-1:0] best_left_q;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [CHOSEN_W-1:0] chosen_q;
  logic [LEFT_W-1:0]   left_q;

  // Derived values.
  logic [WideW-1:0]     cfg_ext, count_w, slot_ext, idx_ext, best_ext;
  logic                 slot_ok;
  logic [LeftW-1:0]     req_ext, left_ext;
  logic [SIZE_BITS:0]   diff;
  logic                 fits, better;
  logic                 do_load, do_alloc;

  // Effective count is the register clamped to the table depth.
  assign cfg_ext  = WideW'(cfg_q);
  assign count_w  = (cfg_ext > MaxCnt) ? MaxCnt : cfg_ext;
  assign slot_ext = WideW'(slot_q);
  assign slot_ok  = slot_ext < count_w;
  assign idx_ext  = WideW'(idx_q);
  assign best_ext = WideW'(best_idx_q);
  assign req_ext  = LeftW'(in_size_i);
  assign left_ext = LeftW'(best_left_q);

  // Status toward the controller.
  always_comb begin
    sts_o.new_is_alloc = (in_func_i == FUNC_ALLOC);
    sts_o.count_zero   = (count_w == '0);
    sts_o.scan_last    = (idx_ext == count_w - WideW'(1));
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Compare stage: one subtract gives both the fit test and the leftover.
  assign diff   = {1'b0, rd_size_q} - {1'b0, req_q};
  assign fits   = pipe_v_q && !rd_taken_q && !diff[SIZE_BITS];
  assign better = !found_q || (diff[SIZE_BITS-1:0] < best_left_q);

  assign do_load  = cmd_i.finish && (func_q == FUNC_LOAD) && slot_ok;
  assign do_alloc = cmd_i.finish && (func_q == FUNC_ALLOC) && found_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Allocated flags: a load frees its block, an allocation takes one.
  always_comb begin
    taken_d = taken_q;
    if (do_load) begin
      taken_d[slot_ext[IdxW-1:0]] = 1'b0;
    end
    if (do_alloc) begin
      taken_d[best_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else begin
      taken_q <= taken_d;
    end
  end

  // Block size memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[slot_ext[IdxW-1:0]] <= req_q;
    end
    if (cmd_i.scan_issue) begin
      rd_size_q  <= mem_q[idx_q];
      rd_taken_q <= taken_q[idx_q];
      cmp_idx_q  <= idx_q;
    end
  end

  // Compare stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q <= 1'b0;
    end else begin
      pipe_v_q <= cmd_i.scan_issue;
    end
  end

  // Item capture, scan index and best candidate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_func_i;
      slot_q  <= in_block_index_i;
      req_q   <= req_ext[SIZE_BITS-1:0];
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.scan_issue) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (fits && better) begin
        found_q     <= 1'b1;
        best_idx_q  <= cmp_idx_q;
        best_left_q <= diff[SIZE_BITS-1:0];
      end
    end
  end

  // Result register valid bit.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= ST_LOADED;
      chosen_q <= '0;
      left_q   <= '0;
      if (func_q == FUNC_LOAD) begin
        if (!slot_ok) begin
          status_q <= ST_RANGE;
        end
      end else if (found_q) begin
        status_q <= ST_ALLOCATED;
        chosen_q <= best_ext[CHOSEN_W-1:0];
        left_q   <= left_ext[LEFT_W-1:0];
      end else begin
        status_q <= ST_NOFIT;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = status_q;
  assign out_chosen_block_o = chosen_q;
  assign out_leftover_o     = left_q;

endmodule

// ----- rtl/best_fit_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core
// Best-fit block allocator: loads block sizes into a table and serves
// allocation requests with the free block that leaves the smallest leftover.
//
//   Channel   Dir  Handshake       Item
//   in_i      in   valid/ready     func, block_index, size
//   out_o     out  valid/ready     status, chosen_block, leftover
//   cfg       in   cfg_we_i        blocks_in_use (cfg_wdata_i)
//
// A load, or a request with no block in use, goes from idle straight to the
// done state; a request scans the N blocks in use, N being blocks_in_use
// clamped to MAX_BLOCKS, reading the size memory one block per cycle through
// one compare stage, then drains that stage before the done state.
// Reset frees every block and sets blocks_in_use to 16; block sizes hold
// no value until loaded. A result waits in the output register while the
// next item is taken; that item's result waits until the register frees.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_core import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bfa_in_if.sink           in_i,
  bfa_out_if.source        out_o
);

  bfa_cmd_t cmd;
  bfa_sts_t sts;
  logic     in_ready;
  logic     accept;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Controller.
  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // Datapath.
  bfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_func_i          (in_i.func),
    .in_block_index_i   (in_i.block_index),
    .in_size_i          (in_i.size),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_status_o       (out_o.status),
    .out_chosen_block_o (out_o.chosen_block),
    .out_leftover_o     (out_o.leftover)
  );

  // A result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_o.valid || out_o.ready))
    else $error("result written over a pending result");

  // A new result shows up only after the controller finished an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.finish))
    else $error("result appeared without a finished item");

  // No item is taken while a scan is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_issue |-> !in_i.ready)
    else $error("input ready during a scan");

endmodule
